// ----- hw/rtl/brf_pkg.sv -----
package brf_pkg;

    // Ring geometry. The count and length fields are 11 bits wide, so the
    // ring holds exactly 1024 bytes and the pointer wraps by truncation.
    localparam int CAPACITY = 1024;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 11;
    localparam int LEN_W    = 11;
    localparam int EVT_W    = 32;
    localparam int TOT_W    = 48;

    // Configuration port geometry.
    localparam int APB_AW = 1;
    localparam int APB_DW = 32;
    localparam int MODE_W = 2;

    localparam logic [APB_AW-1:0] ADDR_OVERFLOW_MODE = '0;

    // Item operations.
    typedef enum logic [1:0] {
        OP_WRITE       = 2'd0,
        OP_READ        = 2'd1,
        OP_CLEAR_BUF   = 2'd2,
        OP_CLEAR_STATS = 2'd3
    } t_op;

    // Overflow policies. Code 3 is unused and acts as drop newest.
    typedef enum logic [MODE_W-1:0] {
        MODE_BLOCK     = 2'd0,
        MODE_OVERWRITE = 2'd1,
        MODE_DROP      = 2'd2
    } t_mode;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_DROPPED     = 3'd2,
        ST_WOULD_BLOCK = 3'd3,
        ST_OVERRUN     = 3'd4,
        ST_TOO_LONG    = 3'd5
    } t_status;

    // One input item.
    typedef struct packed {
        t_op              operation;
        logic [7:0]       data;
        logic             chunk_start;
        logic [LEN_W-1:0] chunk_len;
    } t_brf_item;

    // One result item.
    typedef struct packed {
        logic [7:0]       read_data;
        t_status          status;
        logic [CNT_W-1:0] fill_level;
        logic [EVT_W-1:0] overrun_total;
        logic [EVT_W-1:0] underrun_total;
        logic [CNT_W-1:0] peak_fill;
        logic [TOT_W-1:0] bytes_written_total;
        logic [TOT_W-1:0] bytes_read_total;
    } t_brf_result;

    // Access request to the byte store.
    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } t_store_cmd;

endpackage

// ----- hw/rtl/brf_store.sv -----
module brf_store
    import brf_pkg::*;
(
    input  logic       i_clk,
    input  t_store_cmd i_cmd,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [CAPACITY];
    logic [7:0] r_rd_data;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/byte_ring_fifo_overflow_policy.sv -----
// Byte ring FIFO with chunked writes and a selectable overflow policy.
// Input channel: i_in_valid / o_in_stall carry one item per transfer, which
// writes one byte of a chunk, pops one byte, clears the ring or clears the
// statistics. The first byte of a chunk carries its length, and the whole
// chunk is judged against free space at that byte.
// Output channel: o_out_valid / i_out_stall carry exactly one result per item:
// the popped byte, a status code, the fill level and the statistics.
// The result of an item accepted at a clock edge is valid after that edge.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single byte store port and the registered state update.
// When the receiver stalls, the result holds and o_in_stall rises, so no new
// item enters until the result is taken; a new item may enter in the same
// cycle the held result is taken.
// Reset clears pointers, fill, chunk tracking and all counters and selects
// overwrite mode. Store contents are not cleared; the fill accounting never
// reads an unwritten byte. The policy register sits at address 0 of the
// APB-style port and should be written only while the block is idle.
module byte_ring_fifo_overflow_policy
    import brf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // Item channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_brf_item         i_in_data,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_brf_result       o_out_data
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [MODE_W-1:0] r_mode;

    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic              r_acc, n_acc;
    logic [EVT_W-1:0]  r_ovr, n_ovr;
    logic [EVT_W-1:0]  r_und, n_und;
    logic [CNT_W-1:0]  r_peak, n_peak;
    logic [TOT_W-1:0]  r_wr_tot, n_wr_tot;
    logic [TOT_W-1:0]  r_rd_tot, n_rd_tot;

    logic              r_out_valid;
    t_status           r_status, n_status;
    logic              r_rd_hit, n_rd_hit;

    logic              accept;
    logic              chunk_open;
    logic [LEN_W-1:0]  len_eff;
    logic [CNT_W-1:0]  free_space;
    t_store_cmd        store_cmd;
    logic [7:0]        store_q;

    // Configuration register: write on the access phase, read back always.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OVERWRITE;
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_OVERFLOW_MODE) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_OVERFLOW_MODE) ? APB_DW'(r_mode) : '0;

    // Handshake: the result register is the only buffer, so an item enters
    // when the result slot is empty or is being taken this cycle.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // Chunk judgement terms.
    assign chunk_open = i_in_data.chunk_start || (r_rem == '0);
    assign len_eff    = !i_in_data.chunk_start        ? LEN_W'(1) :
                        (i_in_data.chunk_len == '0)   ? LEN_W'(1) :
                                                        i_in_data.chunk_len;
    assign free_space = CAP_CNT - r_fill;

    // Next state and store access for the item on the input.
    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_fill    = r_fill;
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_ovr     = r_ovr;
        n_und     = r_und;
        n_peak    = r_peak;
        n_wr_tot  = r_wr_tot;
        n_rd_tot  = r_rd_tot;
        n_status  = ST_OK;
        n_rd_hit  = 1'b0;
        store_cmd = '0;
        store_cmd.wr_addr = r_wp;
        store_cmd.wr_data = i_in_data.data;
        store_cmd.rd_addr = r_rp;

        case (i_in_data.operation)
            OP_WRITE: begin
                // Judge a new chunk against the free space.
                if (chunk_open) begin
                    n_rem = len_eff;
                    if (len_eff > CAP_CNT) begin
                        n_acc    = 1'b0;
                        n_status = ST_TOO_LONG;
                    end else if (len_eff <= free_space) begin
                        n_acc = 1'b1;
                    end else if (r_mode == MODE_OVERWRITE) begin
                        // Skip the oldest bytes so the whole chunk fits.
                        n_rp     = r_rp + PTR_W'(len_eff - free_space);
                        n_fill   = CAP_CNT - len_eff;
                        n_ovr    = (r_ovr == '1) ? r_ovr : r_ovr + EVT_W'(1);
                        n_acc    = 1'b1;
                        n_status = ST_OVERRUN;
                    end else begin
                        n_acc    = 1'b0;
                        n_status = (r_mode == MODE_BLOCK) ? ST_WOULD_BLOCK
                                                          : ST_DROPPED;
                    end
                end
                if (n_rem != '0) begin
                    n_rem = n_rem - LEN_W'(1);
                end
                // Store the byte if the chunk was taken and the ring has room.
                if (!n_acc) begin
                    if (n_status == ST_OK) begin
                        n_status = ST_DROPPED;
                    end
                end else if (n_fill >= CAP_CNT) begin
                    n_status = ST_DROPPED;
                end else begin
                    store_cmd.wr_en = 1'b1;
                    n_wp     = r_wp + PTR_W'(1);
                    n_fill   = n_fill + CNT_W'(1);
                    n_wr_tot = (r_wr_tot == '1) ? r_wr_tot : r_wr_tot + TOT_W'(1);
                    if (n_fill > r_peak) begin
                        n_peak = n_fill;
                    end
                end
            end
            OP_READ: begin
                if (r_fill == '0) begin
                    n_und    = (r_und == '1) ? r_und : r_und + EVT_W'(1);
                    n_status = ST_EMPTY;
                end else begin
                    store_cmd.rd_en = 1'b1;
                    n_rd_hit = 1'b1;
                    n_rp     = r_rp + PTR_W'(1);
                    n_fill   = r_fill - CNT_W'(1);
                    n_rd_tot = (r_rd_tot == '1) ? r_rd_tot : r_rd_tot + TOT_W'(1);
                end
            end
            OP_CLEAR_BUF: begin
                // An open chunk stays open across a buffer clear.
                n_wp   = '0;
                n_rp   = '0;
                n_fill = '0;
            end
            OP_CLEAR_STATS: begin
                n_ovr    = '0;
                n_und    = '0;
                n_peak   = '0;
                n_wr_tot = '0;
                n_rd_tot = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase

        if (!accept) begin
            store_cmd.wr_en = 1'b0;
            store_cmd.rd_en = 1'b0;
        end
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_rem       <= '0;
            r_acc       <= 1'b0;
            r_ovr       <= '0;
            r_und       <= '0;
            r_peak      <= '0;
            r_wr_tot    <= '0;
            r_rd_tot    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_wp     <= n_wp;
                r_rp     <= n_rp;
                r_fill   <= n_fill;
                r_rem    <= n_rem;
                r_acc    <= n_acc;
                r_ovr    <= n_ovr;
                r_und    <= n_und;
                r_peak   <= n_peak;
                r_wr_tot <= n_wr_tot;
                r_rd_tot <= n_rd_tot;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_rd_hit <= n_rd_hit;
        end
    end

    brf_store u_store (
        .i_clk     (i_clk),
        .i_cmd     (store_cmd),
        .o_rd_data (store_q)
    );

    // The statistics registers change only on a transfer, so they hold the
    // values left by the item whose result is shown.
    always_comb begin
        o_out_data.read_data           = r_rd_hit ? store_q : 8'd0;
        o_out_data.status              = r_status;
        o_out_data.fill_level          = r_fill;
        o_out_data.overrun_total       = r_ovr;
        o_out_data.underrun_total      = r_und;
        o_out_data.peak_fill           = r_peak;
        o_out_data.bytes_written_total = r_wr_tot;
        o_out_data.bytes_read_total    = r_rd_tot;
    end

endmodule
